@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rtl of the incremental pid block
// no dependencies; expects signals named clock and reset in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_PROP(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/ips_pkg.sv @@
// shared constants, register codes and config struct for the incremental pid block
// no dependencies
package ips_pkg;

   localparam int VALUE_FRAC_BITS = 16;
   localparam int GAIN_FRAC_BITS  = 8;

   localparam int VALUE_W  = 32;
   localparam int GAIN_W   = 16;
   localparam int LIMIT_W  = 31;
   localparam int WEIGHT_W = 17;
   localparam int IDX_W    = 3;

   // shared multiplier: signed operand by unsigned operand
   localparam int MUL_A_W = 36;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = 53;

   localparam logic [IDX_W-1:0] REG_GAIN_P     = 3'd0;
   localparam logic [IDX_W-1:0] REG_GAIN_I     = 3'd1;
   localparam logic [IDX_W-1:0] REG_GAIN_D     = 3'd2;
   localparam logic [IDX_W-1:0] REG_SEP_THR    = 3'd3;
   localparam logic [IDX_W-1:0] REG_DEAD_BAND  = 3'd4;
   localparam logic [IDX_W-1:0] REG_FAR_WEIGHT = 3'd5;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

   localparam logic [GAIN_W-1:0]   GAIN_P_RST = GAIN_W'(5 << GAIN_FRAC_BITS);
   localparam logic [GAIN_W-1:0]   GAIN_I_RST = GAIN_W'(((92 << GAIN_FRAC_BITS) + 5) / 10);
   localparam logic [GAIN_W-1:0]   GAIN_D_RST = '0;
   localparam logic [LIMIT_W-1:0]  SEP_THR_RST = LIMIT_W'(1 << (VALUE_FRAC_BITS - 1));
   localparam logic [LIMIT_W-1:0]  DEAD_BAND_RST = LIMIT_W'(((1 << VALUE_FRAC_BITS) + 5) / 10);
   localparam logic [WEIGHT_W-1:0] FAR_WEIGHT_RST = 17'd26214;

   localparam logic signed [VALUE_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] S32_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [GAIN_W-1:0]   gain_p;
      logic [GAIN_W-1:0]   gain_i;
      logic [GAIN_W-1:0]   gain_d;
      logic [LIMIT_W-1:0]  sep_thr;
      logic [LIMIT_W-1:0]  dead_band;
      logic [WEIGHT_W-1:0] far_weight;
   } cfg_type;

endpackage

@@ rtl/core/incremental_pid_integral_separation.sv @@
// Incremental PID controller with integral separation and a dead band. Each setpoint item
// yields one result: the accumulated output (Q16.16, clamped to 32 bits) and a flag set
// when that clamp acted. The block takes no new item before the previous result appears;
// the next item can be accepted at the clock edge after the result appears. Each item
// makes five passes through the single shared 36x17 multiplier (integral weight, two
// halves of the integral product, P and D terms) and goes through the error, rounding
// and update steps. If the previous result has not yet been taken, the update step waits
// for it. Configuration writes are always ready.
// depends on ips_pkg, ips_mul, ips_csr and assert_macros.svh
`include "assert_macros.svh"

module incremental_pid_integral_separation
   import ips_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [VALUE_W-1:0] req_setpoint,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [VALUE_W-1:0] rsp_control_out,
   output logic                      rsp_saturated,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [IDX_W-1:0]          csr_index,
   input  logic [LIMIT_W-1:0]        csr_data
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SEP  = 4'd1;
   localparam logic [3:0] ST_DIFF = 4'd2;
   localparam logic [3:0] ST_ILO  = 4'd3;
   localparam logic [3:0] ST_IHI  = 4'd4;
   localparam logic [3:0] ST_PT   = 4'd5;
   localparam logic [3:0] ST_DT   = 4'd6;
   localparam logic [3:0] ST_ACC  = 4'd7;
   localparam logic [3:0] ST_RND  = 4'd8;
   localparam logic [3:0] ST_UPD  = 4'd9;

   localparam logic signed [MUL_P_W-1:0] RND_HALF = MUL_P_W'(1 << (GAIN_FRAC_BITS - 1));

   cfg_type cfg;

   logic signed [MUL_A_W-1:0] mul_a;
   logic        [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod;

   // control state
   logic [3:0]                state_ff, state_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] out_acc_ff, out_acc_in;
   logic signed [VALUE_W-1:0] e1_ff, e1_in;
   logic signed [VALUE_W-1:0] e2_ff, e2_in;

   // working registers
   logic signed [VALUE_W-1:0]  e_raw_ff, e_raw_in;
   logic signed [VALUE_W-1:0]  e_ff, e_in;
   logic [WEIGHT_W-1:0]        w_ff, w_in;
   logic signed [VALUE_W:0]    dp_ff, dp_in;
   logic [VALUE_W:0]           sim_ff, sim_in;
   logic                       sineg_ff, sineg_in;
   logic signed [VALUE_W+2:0]  dd_ff, dd_in;
   logic [15:0]                kw_ff, kw_in;
   logic [63:0]                iacc_ff, iacc_in;
   logic signed [MUL_P_W-1:0]  sum_ff, sum_in;
   logic signed [MUL_P_W-1:0]  inc_ff, inc_in;
   logic signed [VALUE_W-1:0]  rsp_out_ff, rsp_out_in;
   logic                       rsp_sat_ff, rsp_sat_in;

   // combinational helpers
   logic signed [VALUE_W:0]   diff;
   logic signed [VALUE_W-1:0] e_clamp;
   logic [VALUE_W-1:0]        emag;
   logic                      in_dead;
   logic                      near;
   logic [WEIGHT_W-1:0]       far_cl;
   logic signed [VALUE_W:0]   si;
   logic signed [MUL_P_W-1:0] rnd;
   logic signed [MUL_P_W:0]   nxt;
   logic                      nxt_ovf;
   logic                      upd_go;

   ips_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ips_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_control_out = rsp_out_ff;
   assign rsp_saturated   = rsp_sat_ff;

   // error against own output, saturated to 32 bits
   assign diff    = $signed({req_setpoint[VALUE_W-1], req_setpoint})
                  - $signed({out_acc_ff[VALUE_W-1], out_acc_ff});
   assign e_clamp = (diff[VALUE_W] != diff[VALUE_W-1])
                  ? (diff[VALUE_W] ? S32_MIN : S32_MAX) : diff[VALUE_W-1:0];

   assign emag    = e_raw_ff[VALUE_W-1] ? (~e_raw_ff + 32'd1) : e_raw_ff;
   assign in_dead = (emag <= {1'b0, cfg.dead_band});
   assign near    = in_dead || (emag <= {1'b0, cfg.sep_thr});
   assign far_cl  = (cfg.far_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.far_weight;

   assign si = $signed({e_ff[VALUE_W-1], e_ff}) + $signed({e1_ff[VALUE_W-1], e1_ff});

   // half away from zero: negative sums take one less of bias before the arithmetic shift
   assign rnd = sum_ff + (sum_ff[MUL_P_W-1] ? (RND_HALF - MUL_P_W'(1)) : RND_HALF);

   assign nxt     = $signed({{(MUL_P_W+1-VALUE_W){out_acc_ff[VALUE_W-1]}}, out_acc_ff})
                  + $signed({inc_ff[MUL_P_W-1], inc_ff});
   assign nxt_ovf = (nxt[MUL_P_W:VALUE_W-1] != {(MUL_P_W-VALUE_W+2){nxt[MUL_P_W]}});
   assign upd_go  = (state_ff == ST_UPD) && (!rsp_valid_ff || !rsp_stall);

   // operand selection for the shared multiplier
   always_comb begin
      case (state_ff)
         ST_DIFF: begin
            mul_a = $signed({{(MUL_A_W-WEIGHT_W){1'b0}}, w_ff});
            mul_b = {1'b0, cfg.gain_i};
         end
         ST_ILO: begin
            mul_a = $signed({3'b000, sim_ff});
            mul_b = {1'b0, prod[15:0]};
         end
         ST_IHI: begin
            mul_a = $signed({3'b000, sim_ff});
            mul_b = {1'b0, kw_ff};
         end
         ST_PT: begin
            mul_a = $signed({{3{dp_ff[VALUE_W]}}, dp_ff});
            mul_b = {1'b0, cfg.gain_p};
         end
         ST_DT: begin
            mul_a = $signed({dd_ff[VALUE_W+2], dd_ff});
            mul_b = {1'b0, cfg.gain_d};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_acc_in   = out_acc_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      e_raw_in     = e_raw_ff;
      e_in         = e_ff;
      w_in         = w_ff;
      dp_in        = dp_ff;
      sim_in       = sim_ff;
      sineg_in     = sineg_ff;
      dd_in        = dd_ff;
      kw_in        = kw_ff;
      iacc_in      = iacc_ff;
      sum_in       = sum_ff;
      inc_in       = inc_ff;
      rsp_out_in   = rsp_out_ff;
      rsp_sat_in   = rsp_sat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               e_raw_in = e_clamp;
               state_in = ST_SEP;
            end
         end
         ST_SEP: begin
            e_in     = in_dead ? '0 : e_raw_ff;
            w_in     = near ? WEIGHT_ONE : far_cl;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            dp_in    = $signed({e_ff[VALUE_W-1], e_ff}) - $signed({e1_ff[VALUE_W-1], e1_ff});
            sineg_in = si[VALUE_W];
            sim_in   = si[VALUE_W] ? (~si + 33'd1) : si;
            dd_in    = $signed({{3{e_ff[VALUE_W-1]}}, e_ff})
                     - $signed({{2{e1_ff[VALUE_W-1]}}, e1_ff, 1'b0})
                     + $signed({{3{e2_ff[VALUE_W-1]}}, e2_ff});
            state_in = ST_ILO;
         end
         ST_ILO: begin
            kw_in    = prod[31:16];
            state_in = ST_IHI;
         end
         ST_IHI: begin
            iacc_in  = {15'd0, prod[48:0]};
            state_in = ST_PT;
         end
         ST_PT: begin
            iacc_in  = iacc_ff + {prod[47:0], 16'd0} + 64'h1_0000;
            state_in = ST_DT;
         end
         ST_DT: begin
            // prod holds the proportional term here
            sum_in   = sineg_ff ? (prod - $signed({6'd0, iacc_ff[63:17]}))
                                : (prod + $signed({6'd0, iacc_ff[63:17]}));
            state_in = ST_ACC;
         end
         ST_ACC: begin
            sum_in   = sum_ff + prod;
            state_in = ST_RND;
         end
         ST_RND: begin
            inc_in   = rnd >>> GAIN_FRAC_BITS;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (upd_go) begin
               out_acc_in   = nxt_ovf ? (nxt[MUL_P_W] ? S32_MIN : S32_MAX)
                                      : nxt[VALUE_W-1:0];
               rsp_out_in   = out_acc_in;
               rsp_sat_in   = nxt_ovf;
               rsp_valid_in = 1'b1;
               e2_in        = e1_ff;
               e1_in        = e_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         out_acc_ff   <= '0;
         e1_ff        <= '0;
         e2_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         out_acc_ff   <= out_acc_in;
         e1_ff        <= e1_in;
         e2_ff        <= e2_in;
      end
   end

   always_ff @(posedge clock) begin
      e_raw_ff   <= e_raw_in;
      e_ff       <= e_in;
      w_ff       <= w_in;
      dp_ff      <= dp_in;
      sim_ff     <= sim_in;
      sineg_ff   <= sineg_in;
      dd_ff      <= dd_in;
      kw_ff      <= kw_in;
      iacc_ff    <= iacc_in;
      sum_ff     <= sum_in;
      inc_ff     <= inc_in;
      rsp_out_ff <= rsp_out_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   `ASSERT_PROP(a_rsp_from_update, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_UPD, "result raised outside the update step")
   `ASSERT_PROP(a_sat_at_limit, (rsp_valid_ff && rsp_sat_ff) |-> (rsp_out_ff == S32_MAX || rsp_out_ff == S32_MIN), "saturated result not at a limit")
   `ASSERT_NEXT(a_kw_fits, state_ff == ST_DIFF, prod[MUL_P_W-1:32] == '0, "integral weight product exceeds 32 bits")
   `ASSERT_NEXT(a_accept_starts, req_valid && !req_stall, state_ff == ST_SEP, "accepted item did not start the sequence")

endmodule

@@ rtl/core/ips_mul.sv @@
// shared multiplier of the incremental pid block, signed by unsigned, registered product
// depends on ips_pkg
module ips_mul
   import ips_pkg::*;
(
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] op_a,
   input  logic        [MUL_B_W-1:0] op_b,
   output logic signed [MUL_P_W-1:0] prod
);

   logic signed [MUL_A_W+MUL_B_W:0] full;
   logic signed [MUL_P_W-1:0]       prod_in;
   logic signed [MUL_P_W-1:0]       prod_ff;

   // operands are bounded so the product never needs the top bit
   assign full    = op_a * $signed({1'b0, op_b});
   assign prod_in = full[MUL_P_W-1:0];
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

@@ rtl/core/ips_csr.sv @@
// configuration registers of the incremental pid block
// depends on ips_pkg
module ips_csr
   import ips_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [LIMIT_W-1:0] csr_data,
   output cfg_type            cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_GAIN_P:     cfg_in.gain_p     = csr_data[GAIN_W-1:0];
            REG_GAIN_I:     cfg_in.gain_i     = csr_data[GAIN_W-1:0];
            REG_GAIN_D:     cfg_in.gain_d     = csr_data[GAIN_W-1:0];
            REG_SEP_THR:    cfg_in.sep_thr    = csr_data;
            REG_DEAD_BAND:  cfg_in.dead_band  = csr_data;
            REG_FAR_WEIGHT: cfg_in.far_weight = csr_data[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p     <= GAIN_P_RST;
         cfg_ff.gain_i     <= GAIN_I_RST;
         cfg_ff.gain_d     <= GAIN_D_RST;
         cfg_ff.sep_thr    <= SEP_THR_RST;
         cfg_ff.dead_band  <= DEAD_BAND_RST;
         cfg_ff.far_weight <= FAR_WEIGHT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
